// ===== design/p1tlc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the P1 telegram line checker.
// No dependencies; used by every module of the block.
package p1tlc_pkg;

    localparam int NumCodes  = 19;
    localparam int PatMaxLen = 27;

    localparam logic [4:0] IDX_NONE = 5'd19;

    localparam logic [6:0] CH_SLASH = 7'h2F;
    localparam logic [6:0] CH_BANG  = 7'h21;
    localparam logic [6:0] CH_NL    = 7'h0A;

    localparam logic [7:0] PAT_DIGIT = 8'h23;
    localparam logic [7:0] PAT_ANY   = 8'h40;
    localparam logic [7:0] PAT_NUM   = 8'h24;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LINE     = 3'd1,
        ST_CRC_ERR  = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  code_index;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } result_t;

    // Patterns are right-aligned in the packed word: char p of a pattern of
    // length L sits at bits [(L-1-p)*8 +: 8].
    localparam logic [8*PatMaxLen-1:0] PATTERN [NumCodes] = '{
        "1-0:1.8.1($",  "1-0:1.8.2($",  "1-0:2.8.1($",  "1-0:2.8.2($",
        "1-0:1.7.0($",  "1-0:21.7.0($", "1-0:41.7.0($", "1-0:61.7.0($",
        "1-0:2.7.0($",  "1-0:22.7.0($", "1-0:42.7.0($", "1-0:62.7.0($",
        "1-0:32.7.0($", "1-0:52.7.0($", "1-0:72.7.0($", "1-0:31.7.0($",
        "1-0:51.7.0($", "1-0:71.7.0($",
        "0-1:24.2.1(############@)($"
    };

    localparam logic [4:0] PAT_LEN [NumCodes] = '{
        5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd12, 5'd11, 5'd12,
        5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12, 5'd27
    };

endpackage

// ===== design/p1_telegram_line_checker.sv =====
`timescale 1ns / 1ps
// P1 telegram line checker, top level: input register, line processor and
// result register. Uses p1tlc_pkg and p1tlc_line_proc.
//
// Input channel: rx_byte with in_valid / in_stall; one byte per request,
// bit 7 ignored. Output channel: status, code_index, computed_crc and
// received_crc with out_valid / out_stall; one request per finished line
// (newline after at least one other byte) or per overflow.
// Throughput: one byte per cycle while out_stall does not hold a result. A
// byte is registered in the input register when accepted and is processed
// when the result register is free or being read, which loads the result
// register, so results are presented from a register.
// The CRC-16 update, OBIS prefix compare and checksum digit parse all
// complete combinationally between the input and result registers.
// Lines of BUFFER_SIZE or more bytes are dropped with an overflow result.
// When out_stall holds a result, the byte in the input register waits and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears the telegram CRC and line state and empties both registers.
module p1_telegram_line_checker #(
    parameter int BUFFER_SIZE = 400
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [4:0]  code_index,
    output logic [15:0] computed_crc,
    output logic [15:0] received_crc
);

    localparam int LenW = $clog2(BUFFER_SIZE);

    logic               in_valid_reg,  in_valid_next;
    logic [6:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    p1tlc_pkg::result_t out_res_reg;

    logic               advance;
    logic               accept;
    logic               step;
    logic               res_valid;
    p1tlc_pkg::result_t res;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign step     = in_valid_reg && advance;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? res_valid : out_valid_reg;

    p1tlc_line_proc #(
        .BUFFER_SIZE (BUFFER_SIZE),
        .LEN_W       (LenW)
    ) u_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .c         (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= rx_byte[6:0];
        if (advance && res_valid)
            out_res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign code_index   = out_res_reg.code_index;
    assign computed_crc = out_res_reg.computed_crc;
    assign received_crc = out_res_reg.received_crc;

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the result register was free");

    a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == p1tlc_pkg::ST_OVERFLOW)
            |-> (code_index == p1tlc_pkg::IDX_NONE && received_crc == 16'h0000))
        else $error("overflow result carries a code or checksum");

    a_ok_means_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == p1tlc_pkg::ST_OK) |-> (computed_crc == received_crc))
        else $error("telegram reported ok with mismatched checksum");

    a_code_implies_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && code_index != p1tlc_pkg::IDX_NONE)
            |-> (status == p1tlc_pkg::ST_LINE && received_crc == 16'h0000))
        else $error("matched code on a non data line result");

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !step) |=> !out_valid_reg)
        else $error("result appeared without a processed byte");

endmodule

// ===== design/p1tlc_code_match.sv =====
`timescale 1ns / 1ps
// OBIS code matcher: narrows the candidate set by one character and picks
// the lowest candidate whose pattern is complete. Uses p1tlc_pkg.
module p1tlc_code_match #(
    parameter int LEN_W = 9
) (
    input  logic [LEN_W-1:0]                pos,
    input  logic [LEN_W-1:0]                len_new,
    input  logic [6:0]                      c,
    input  logic [p1tlc_pkg::NumCodes-1:0]  cand,
    output logic [p1tlc_pkg::NumCodes-1:0]  cand_new,
    output logic [4:0]                      found
);

    logic [p1tlc_pkg::NumCodes-1:0] keep;
    logic [4:0]                     pos5;
    logic                           pos_in;
    logic                           is_digit;
    logic                           is_num;

    assign pos_in   = pos < LEN_W'(p1tlc_pkg::PatMaxLen);
    assign pos5     = pos[4:0];
    assign is_digit = (c >= 7'h30) && (c <= 7'h39);
    assign is_num   = is_digit || (c == 7'h2B) || (c == 7'h2D) || (c == 7'h2E);

    always_comb
    begin
        logic [7:0] t;
        int         sh;
        keep = '1;
        for (int k = 0; k < p1tlc_pkg::NumCodes; k++)
        begin
            t  = 8'h00;
            sh = 0;
            if (pos_in && (pos5 < p1tlc_pkg::PAT_LEN[k]))
            begin
                sh = (int'(p1tlc_pkg::PAT_LEN[k]) - 1 - int'(pos5)) * 8;
                t  = p1tlc_pkg::PATTERN[k][sh +: 8];
                case (t)
                    p1tlc_pkg::PAT_DIGIT: keep[k] = is_digit;
                    p1tlc_pkg::PAT_ANY:   keep[k] = (c != 7'h00);
                    p1tlc_pkg::PAT_NUM:   keep[k] = is_num;
                    default:              keep[k] = ({1'b0, c} == t);
                endcase
            end
        end
    end

    assign cand_new = cand & keep;

    always_comb
    begin
        found = p1tlc_pkg::IDX_NONE;
        for (int k = p1tlc_pkg::NumCodes - 1; k >= 0; k--)
        begin
            if (cand_new[k] && (len_new >= LEN_W'(p1tlc_pkg::PAT_LEN[k])))
            begin
                found = 5'(k);
            end
        end
    end

endmodule

// ===== design/p1tlc_line_proc.sv =====
`timescale 1ns / 1ps
// Line state, telegram CRC-16 and checksum digit parsing for one byte per
// step. Uses p1tlc_pkg and p1tlc_code_match.
module p1tlc_line_proc #(
    parameter int BUFFER_SIZE = 400,
    parameter int LEN_W       = $clog2(BUFFER_SIZE)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [6:0]           c,
    output logic                 res_valid,
    output p1tlc_pkg::result_t   res
);

    localparam logic [LEN_W-1:0] LenLimit = LEN_W'(BUFFER_SIZE - 1);

    logic [15:0]                    tel_crc_reg,    tel_crc_next;
    logic [15:0]                    line_crc_reg,   line_crc_next;
    logic [LEN_W-1:0]               len_reg,        len_next;
    logic [6:0]                     first_char_reg, first_char_next;
    logic [p1tlc_pkg::NumCodes-1:0] cand_reg,       cand_next;
    logic [15:0]                    hex_value_reg,  hex_value_next;
    logic                           hex_stopped_reg, hex_stopped_next;

    logic [LEN_W-1:0]               len_inc;
    logic [p1tlc_pkg::NumCodes-1:0] cand_new;
    logic [4:0]                     found;
    logic                           first;
    logic [15:0]                    crc_seed;
    logic [15:0]                    crc_upd;
    logic [15:0]                    line_crc_new;
    logic [4:0]                     hex_d;
    logic [15:0]                    hex_new;
    logic                           hex_stop_new;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [6:0] b);
        logic [15:0] r;
        r = crc_in ^ {9'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_digit(input logic [6:0] ch);
        logic [4:0] d;
        if (ch >= 7'h30 && ch <= 7'h39)
            d = 5'(ch - 7'h30);
        else if (ch >= 7'h61 && ch <= 7'h66)
            d = 5'(ch - 7'h57);
        else if (ch >= 7'h41 && ch <= 7'h46)
            d = 5'(ch - 7'h37);
        else
            d = 5'h10;
        return d;
    endfunction

    assign len_inc = len_reg + LEN_W'(1);
    assign first   = (len_reg == '0);

    p1tlc_code_match #(
        .LEN_W    (LEN_W)
    ) u_match (
        .pos      (len_reg),
        .len_new  (len_inc),
        .c        (c),
        .cand     (cand_reg),
        .cand_new (cand_new),
        .found    (found)
    );

    assign crc_seed = first ? ((c == p1tlc_pkg::CH_SLASH) ? 16'h0000 : tel_crc_reg)
                            : line_crc_reg;
    assign crc_upd  = crc_byte(crc_seed, c);
    assign line_crc_new = (first || first_char_reg != p1tlc_pkg::CH_BANG) ? crc_upd
                                                                          : line_crc_reg;
    assign hex_d = hex_digit(c);

    always_comb
    begin
        hex_new      = hex_value_reg;
        hex_stop_new = hex_stopped_reg;
        if (!first && first_char_reg == p1tlc_pkg::CH_BANG
            && len_reg <= LEN_W'(4) && !hex_stopped_reg)
        begin
            if (hex_d[4])
                hex_stop_new = 1'b1;
            else
                hex_new = {hex_value_reg[11:0], hex_d[3:0]};
        end
    end

    always_comb
    begin
        tel_crc_next     = tel_crc_reg;
        line_crc_next    = line_crc_reg;
        len_next         = len_reg;
        first_char_next  = first_char_reg;
        cand_next        = cand_reg;
        hex_value_next   = hex_value_reg;
        hex_stopped_next = hex_stopped_reg;
        res_valid        = 1'b0;
        res.status       = p1tlc_pkg::ST_UNKNOWN;
        res.code_index   = p1tlc_pkg::IDX_NONE;
        res.computed_crc = line_crc_new;
        res.received_crc = 16'h0000;

        if (step)
        begin
            if (len_reg >= LenLimit)
            begin
                res_valid        = 1'b1;
                res.status       = p1tlc_pkg::ST_OVERFLOW;
                res.computed_crc = tel_crc_reg;
                line_crc_next    = 16'h0000;
                len_next         = '0;
                first_char_next  = 7'h00;
                cand_next        = '1;
                hex_value_next   = 16'h0000;
                hex_stopped_next = 1'b0;
            end
            else if (c == p1tlc_pkg::CH_NL && !first)
            begin
                res_valid = 1'b1;
                if (first_char_reg == p1tlc_pkg::CH_SLASH)
                begin
                    res.status   = p1tlc_pkg::ST_LINE;
                    tel_crc_next = line_crc_new;
                end
                else if (first_char_reg == p1tlc_pkg::CH_BANG)
                begin
                    res.status       = (hex_new == line_crc_new) ? p1tlc_pkg::ST_OK
                                                                 : p1tlc_pkg::ST_CRC_ERR;
                    res.received_crc = hex_new;
                    tel_crc_next     = 16'h0000;
                end
                else
                begin
                    res.code_index = found;
                    res.status     = (found == p1tlc_pkg::IDX_NONE) ? p1tlc_pkg::ST_UNKNOWN
                                                                    : p1tlc_pkg::ST_LINE;
                    tel_crc_next   = line_crc_new;
                end
                line_crc_next    = 16'h0000;
                len_next         = '0;
                first_char_next  = 7'h00;
                cand_next        = '1;
                hex_value_next   = 16'h0000;
                hex_stopped_next = 1'b0;
            end
            else
            begin
                line_crc_next    = line_crc_new;
                len_next         = len_inc;
                first_char_next  = first ? c : first_char_reg;
                cand_next        = cand_new;
                hex_value_next   = hex_new;
                hex_stopped_next = hex_stop_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tel_crc_reg     <= 16'h0000;
            line_crc_reg    <= 16'h0000;
            len_reg         <= '0;
            first_char_reg  <= 7'h00;
            cand_reg        <= '1;
            hex_value_reg   <= 16'h0000;
            hex_stopped_reg <= 1'b0;
        end
        else
        begin
            tel_crc_reg     <= tel_crc_next;
            line_crc_reg    <= line_crc_next;
            len_reg         <= len_next;
            first_char_reg  <= first_char_next;
            cand_reg        <= cand_next;
            hex_value_reg   <= hex_value_next;
            hex_stopped_reg <= hex_stopped_next;
        end
    end

endmodule

// ===== test/p1_line_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for p1_telegram_line_checker: predicts line results from the accepted bytes
// and compares them with the results that leave the block. Needs p1tlc_pkg for its types.
module p1_line_result_checker #(
    parameter int LINE_LIMIT = 400
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [4:0]  code_index,
    input  logic [15:0] computed_crc,
    input  logic [15:0] received_crc,
    output int          fail_count,
    output int          lines_pending
);
    import p1tlc_pkg::*;

    localparam logic [18:0] ALL_CODES = '1;

    string obis_text [NumCodes] = '{
        "1-0:1.8.1($",  "1-0:1.8.2($",  "1-0:2.8.1($",  "1-0:2.8.2($",
        "1-0:1.7.0($",  "1-0:21.7.0($", "1-0:41.7.0($", "1-0:61.7.0($",
        "1-0:2.7.0($",  "1-0:22.7.0($", "1-0:42.7.0($", "1-0:62.7.0($",
        "1-0:32.7.0($", "1-0:52.7.0($", "1-0:72.7.0($", "1-0:31.7.0($",
        "1-0:51.7.0($", "1-0:71.7.0($",
        "0-1:24.2.1(############@)($"
    };

    logic [15:0] telegram_sum;
    logic [15:0] line_sum;
    int unsigned line_len;
    logic [6:0]  lead_ch;
    logic [18:0] code_alive;
    logic [15:0] hex_acc;
    logic        hex_halt;
    result_t     predicted_lines [$];
    int          mismatches;

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [6:0] ch);
        logic [15:0] c;
        c = acc ^ {9'b0, ch};
        repeat (8)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'hA001;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic bit is_digit(input logic [6:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic bit slot_fits(input byte slot, input logic [6:0] ch);
        if (slot == "#")
            return is_digit(ch);
        if (slot == "@")
            return ch != 7'h00;
        if (slot == "$")
            return is_digit(ch) || ch == "+" || ch == "-" || ch == ".";
        return ch == slot[6:0];
    endfunction

    function automatic int hex_nibble(input logic [6:0] ch);
        if (is_digit(ch))
            return int'(ch) - int'("0");
        if (ch >= "a" && ch <= "f")
            return int'(ch) - int'("a") + 10;
        if (ch >= "A" && ch <= "F")
            return int'(ch) - int'("A") + 10;
        return -1;
    endfunction

    task automatic restart_line();
        line_sum   = 16'h0000;
        line_len   = 0;
        lead_ch    = 7'h00;
        code_alive = ALL_CODES;
        hex_acc    = 16'h0000;
        hex_halt   = 1'b0;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: line result mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic absorb_byte(input logic [7:0] raw);
        logic [6:0]  ch;
        int unsigned pos;
        int          nib;
        int          hit;
        int          k;
        result_t     res;
        ch  = raw[6:0];
        pos = line_len;
        if (pos >= LINE_LIMIT - 1)
        begin
            res.status       = ST_OVERFLOW;
            res.code_index   = IDX_NONE;
            res.computed_crc = telegram_sum;
            res.received_crc = 16'h0000;
            predicted_lines.push_back(res);
            restart_line();
        end
        else
        begin
            if (pos == 0)
            begin
                lead_ch  = ch;
                line_sum = crc16_step((ch == CH_SLASH) ? 16'h0000 : telegram_sum, ch);
            end
            else if (lead_ch != CH_BANG)
                line_sum = crc16_step(line_sum, ch);

            if (lead_ch == CH_BANG && pos >= 1 && pos <= 4 && !hex_halt)
            begin
                nib = hex_nibble(ch);
                if (nib < 0)
                    hex_halt = 1'b1;
                else
                    hex_acc = {hex_acc[11:0], nib[3:0]};
            end

            for (k = 0; k < NumCodes; k++)
            begin
                if (code_alive[k] && pos < obis_text[k].len()
                    && !slot_fits(obis_text[k][pos], ch))
                    code_alive[k] = 1'b0;
            end

            line_len = pos + 1;

            if (ch == CH_NL && line_len > 1)
            begin
                res.code_index   = IDX_NONE;
                res.computed_crc = line_sum;
                res.received_crc = 16'h0000;
                if (lead_ch == CH_SLASH)
                begin
                    telegram_sum = line_sum;
                    res.status   = ST_LINE;
                end
                else if (lead_ch == CH_BANG)
                begin
                    res.status       = (hex_acc == line_sum) ? ST_OK : ST_CRC_ERR;
                    res.received_crc = hex_acc;
                    telegram_sum     = 16'h0000;
                end
                else
                begin
                    telegram_sum = line_sum;
                    hit = IDX_NONE;
                    // lowest index wins
                    for (k = NumCodes - 1; k >= 0; k--)
                    begin
                        if (code_alive[k] && line_len >= obis_text[k].len())
                            hit = k;
                    end
                    res.status     = (hit == IDX_NONE) ? ST_UNKNOWN : ST_LINE;
                    res.code_index = 5'(hit);
                end
                predicted_lines.push_back(res);
                restart_line();
            end
        end
    endtask

    task automatic check_result();
        result_t want;
        if (predicted_lines.size() == 0)
            report_mismatch($sformatf("result status %0d with no line pending", status));
        else
        begin
            want = predicted_lines.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            if (code_index !== want.code_index)
                report_mismatch($sformatf("code_index %0d, want %0d", code_index,
                                          want.code_index));
            if (computed_crc !== want.computed_crc)
                report_mismatch($sformatf("computed_crc %h, want %h", computed_crc,
                                          want.computed_crc));
            if (received_crc !== want.received_crc)
                report_mismatch($sformatf("received_crc %h, want %h", received_crc,
                                          want.received_crc));
        end
    endtask

    // outputs before inputs: a request taken at this edge cannot finish a line yet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            telegram_sum = 16'h0000;
            restart_line();
            predicted_lines.delete();
            mismatches = 0;
            fail_count    <= 0;
            lines_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                absorb_byte(rx_byte);
            fail_count    <= mismatches;
            lines_pending <= predicted_lines.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the p1_telegram_line_checker test: builds telegram byte streams, drives them with
// random gaps and output stalls, and gives the verdict. Needs p1tlc_pkg and the checker.
module testbench;
    import p1tlc_pkg::*;

    localparam int LineLimit   = 400;
    localparam int RandomBytes = 1650;
    localparam int CycleLimit  = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [4:0]  code_index;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    int          fail_count;
    int          lines_pending;

    logic [7:0]  feed_bytes [$];
    logic [7:0]  line_buf [$];
    logic [15:0] tel_sum = 16'h0000;
    int          feed_pos = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    int          code_turn = 0;
    logic        quiet_span;

    string name_chars  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789\\-";
    string value_chars = "0123456789.*kWhVAm3";
    string num_start   = "0123456789+-.";
    string digits      = "0123456789";

    assign quiet_span = cycle_count >= 1500 && cycle_count < 2300;

    always #4 clk = ~clk;

    p1_telegram_line_checker #(
        .BUFFER_SIZE(LineLimit)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .code_index(code_index),
        .computed_crc(computed_crc),
        .received_crc(received_crc)
    );

    p1_line_result_checker #(
        .LINE_LIMIT(LineLimit)
    ) line_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .code_index(code_index),
        .computed_crc(computed_crc),
        .received_crc(received_crc),
        .fail_count(fail_count),
        .lines_pending(lines_pending)
    );

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [6:0] ch);
        logic [15:0] c;
        c = acc ^ {9'b0, ch};
        repeat (8)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'hA001;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick(input string chars);
        return chars[$urandom_range(chars.len() - 1)];
    endfunction

    function automatic logic [7:0] any_char(input bit allow_nul);
        logic [7:0] ch;
        ch = 8'($urandom_range(127));
        while (ch == 8'h0A || (!allow_nul && ch == 8'h00))
            ch = 8'($urandom_range(127));
        return ch;
    endfunction

    // bit 7 is don't-care for the block: set it at random unless forced
    task automatic put_byte(input logic [7:0] b);
        feed_bytes.push_back(b[7] ? b : {($urandom_range(3) == 0), b[6:0]});
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            line_buf.push_back(t[i]);
    endtask

    // emits line_buf plus its end and keeps the telegram CRC in step
    task automatic send_line(input bit bare_nl);
        logic [15:0] acc;
        if (!bare_nl)
            line_buf.push_back(8'h0D);
        line_buf.push_back(8'h0A);
        acc = (line_buf[0][6:0] == CH_SLASH) ? 16'h0000 : tel_sum;
        foreach (line_buf[i])
        begin
            put_byte(line_buf[i]);
            acc = crc16_step(acc, line_buf[i][6:0]);
        end
        tel_sum = (line_buf[0][6:0] == CH_BANG) ? 16'h0000 : acc;
        line_buf.delete();
    endtask

    task automatic header_line();
        line_buf.push_back({1'b0, CH_SLASH});
        repeat ($urandom_range(3, 12))
            line_buf.push_back(pick(name_chars));
        send_line(1'b0);
        if ($urandom_range(1))
            send_line(1'b0);
    endtask

    task automatic data_line(input int k);
        int         plen;
        logic [7:0] slot;
        plen = PAT_LEN[k];
        for (int p = 0; p < plen; p++)
        begin
            slot = PATTERN[k][(plen - 1 - p) * 8 +: 8];
            if (slot == PAT_DIGIT)
                line_buf.push_back(pick(digits));
            else if (slot == PAT_ANY)
                line_buf.push_back(any_char(1'b0));
            else if (slot == PAT_NUM)
                line_buf.push_back(pick(num_start));
            else
                line_buf.push_back(slot);
        end
        repeat ($urandom_range(0, 6))
            line_buf.push_back(pick(value_chars));
        add_text(")");
        if ($urandom_range(99) < 15)
            line_buf[$urandom_range(plen - 1)] = any_char(1'b1);
        send_line($urandom_range(3) == 0);
    endtask

    task automatic noise_line();
        if ($urandom_range(3) == 0)
            line_buf.push_back(8'h0A);
        repeat ($urandom_range(1, 30))
            line_buf.push_back(any_char(1'b1));
        send_line($urandom_range(1));
    endtask

    task automatic checksum_line(input int variant);
        logic [15:0] good;
        string       hex;
        good = crc16_step(tel_sum, CH_BANG);
        if (variant == 6)
            good = good ^ 16'(1 << $urandom_range(15));
        hex = $urandom_range(1) ? $sformatf("%04X", good) : $sformatf("%04x", good);
        line_buf.push_back({1'b0, CH_BANG});
        if (variant <= 6)
        begin
            add_text(hex);
            if ($urandom_range(3) == 0)
                line_buf.push_back(pick("0123456789abcdefZ"));
        end
        else if (variant == 7)
        begin
            for (int i = 0; i < $urandom_range(0, 3); i++)
                line_buf.push_back(hex[i]);
            line_buf.push_back(pick("GgZz* "));
        end
        else if (variant == 8)
        begin
            repeat ($urandom_range(0, 6))
                line_buf.push_back(any_char(1'b1));
        end
        else
        begin
            add_text(hex);
            line_buf[$urandom_range(1, 4)] = pick("gG.x");
        end
        send_line($urandom_range(3) == 0);
    endtask

    task automatic telegram();
        int k;
        if ($urandom_range(9) != 0)
            header_line();
        repeat ($urandom_range(3, 8))
        begin
            if ($urandom_range(9) == 0)
                noise_line();
            else
            begin
                k = $urandom_range(1) ? code_turn % NumCodes : $urandom_range(NumCodes - 1);
                code_turn++;
                data_line(k);
            end
        end
        if ($urandom_range(9) != 0)
            checksum_line($urandom_range(9));
    endtask

    // raw bytes with stray newlines, then a line end to get back in step
    task automatic noise_burst();
        repeat ($urandom_range(5, 40))
            put_byte(8'($urandom_range(255)));
        line_buf.push_back(8'h0D);
        line_buf.push_back(8'h0A);
        foreach (line_buf[i])
            put_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic long_lines();
        // longest line that still fits
        repeat (LineLimit - 3)
            line_buf.push_back(any_char(1'b1));
        send_line(1'b0);
        // one byte too many: the last one goes with the line
        repeat (LineLimit - 1)
            put_byte(any_char(1'b1));
        put_byte(8'($urandom_range(127)));
    endtask

    task automatic build_stream();
        int base;
        int round;
        line_buf.push_back(8'h0A);
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line(1'b1);
        line_buf.push_back({1'b0, CH_SLASH});
        add_text("T");
        send_line(1'b0);
        checksum_line(0);
        add_text("!z");
        send_line(1'b1);
        add_text("!");
        send_line(1'b1);
        base = feed_bytes.size();
        round = 0;
        while (feed_bytes.size() < base + RandomBytes)
        begin
            if (round == 1)
                long_lines();
            if ($urandom_range(4) == 0)
                noise_burst();
            else
                telegram();
            round++;
        end
    endtask

    // request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            feed_pos <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (feed_pos < feed_bytes.size() && (quiet_span || $urandom_range(99) >= 34))
            begin
                in_valid <= 1'b1;
                rx_byte  <= feed_bytes[feed_pos];
                feed_pos <= feed_pos + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side, with two long hold-offs that back up into the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (cycle_count == 700 || cycle_count == 3200)
        begin
            out_stall <= 1'b1;
            hold_left <= 150;
        end
        else
            out_stall <= !quiet_span && ($urandom_range(99) < 34);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        build_stream();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!(feed_pos == feed_bytes.size() && !in_valid && lines_pending == 0))
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (fail_count == 0 && lines_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
